// ===== sv/ssl_pkg.sv =====
// ----------------------------------------------------------------------------
// ssl_pkg: shared types and constants of the streaming source lexer
// Token kinds, scan modes, keyword table and the front-to-back request.
// ----------------------------------------------------------------------------
package ssl_pkg;

  localparam int LINE_W_DEF = 16;
  localparam int COL_W_DEF  = 12;
  localparam int LEN_W_DEF  = 12;
  localparam int NWORDS     = 24;
  localparam int WORD_NIX   = 21;
  localparam int WORD_JA    = 22;
  localparam int MAX_WLEN   = 8;

  localparam logic [5:0] K_UNKNOWN = 6'd0;
  localparam logic [5:0] K_BOOL    = 6'd1;
  localparam logic [5:0] K_IDENT   = 6'd2;
  localparam logic [5:0] K_INT     = 6'd3;
  localparam logic [5:0] K_FLOAT   = 6'd4;
  localparam logic [5:0] K_STRING  = 6'd5;
  localparam logic [5:0] K_END     = 6'd6;
  localparam logic [5:0] K_KW0     = 6'd7;
  localparam logic [5:0] K_EQEQ    = 6'd28;
  localparam logic [5:0] K_NE      = 6'd29;
  localparam logic [5:0] K_LE      = 6'd30;
  localparam logic [5:0] K_GE      = 6'd31;
  localparam logic [5:0] K_SLASH   = 6'd44;
  localparam logic [5:0] K_ASSIGN  = 6'd46;
  localparam logic [5:0] K_LT      = 6'd47;
  localparam logic [5:0] K_GT      = 6'd48;
  localparam logic [5:0] K_BANG    = 6'd49;

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_OPER, M_LINECOM, M_BLOCK, M_BLOCKSTAR
  } mode_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_EQ, OP_BANG, OP_LT, OP_GT, OP_SLASH
  } op_t;

  // Token request from front to back; line/column/length at max width
  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] line;
    logic [31:0] col;
    logic [31:0] len;
    logic        tru;
    logic        last;
  } tok_t;

  function automatic int word_len(int w);
    case (w)
      0, 2, 3, 5, 9, 11, 13, 19, 23: return 4;
      1, 4, 6, 10: return 5;
      7, 14, 16, 17, 18: return 7;
      8, 20, 21: return 3;
      12: return 6;
      15: return 8;
      default: return 2;
    endcase
  endfunction

  function automatic logic [7:0] word_char(int w, int p);
    logic [8*MAX_WLEN-1:0] s;
    case (w)
      0: s = "GANZ";     1: s = "KOMMA";    2: s = "WORT";    3: s = "JAIN";
      4: s = "KISTE";    5: s = "WENN";     6: s = "SONST";   7: s = "SOLANGE";
      8: s = "UND";      9: s = "ODER";     10: s = "NICHT";  11: s = "FUER";
      12: s = "DRUCKE";  13: s = "LESE";    14: s = "ZU_GANZ";
      15: s = {"ZU_", "KOMMA"}; 16: s = "ZU_WORT"; 17: s = "ZURUECK";
      18: s = "GIBFREI"; 19: s = "HOLE";    20: s = "VON";    21: s = "NIX";
      22: s = "JA";      default: s = "NEIN";
    endcase
    // strings are right-aligned; take char p counted from the left
    if (p >= word_len(w)) return 8'd0;
    return s[8*(word_len(w)-1-p) +: 8];
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] c);
    case (c)
      "(": return 6'd32;  ")": return 6'd33;  "{": return 6'd34;
      "}": return 6'd35;  "[": return 6'd36;  "]": return 6'd37;
      ";": return 6'd38;  ",": return 6'd39;  ".": return 6'd40;
      "+": return 6'd41;  "-": return 6'd42;  "*": return 6'd43;
      "%": return 6'd45;  ":": return 6'd50;
      default: return K_UNKNOWN;
    endcase
  endfunction

  function automatic logic [5:0] op_single(op_t p);
    case (p)
      OP_EQ:    return K_ASSIGN;
      OP_BANG:  return K_BANG;
      OP_LT:    return K_LT;
      OP_GT:    return K_GT;
      OP_SLASH: return K_SLASH;
      default:  return K_UNKNOWN;
    endcase
  endfunction

endpackage

// ===== sv/streaming_source_lexer.sv =====
// A token enters the queue when the byte ending it is accepted, behind older tokens.
// Throughput: one byte per cycle while the four-entry token queue has room for two
// tokens; every byte waits for that room, whether it gives none, one or two.
// The output port drains one token per cycle while out_ready is high.
// Reset (rst_n low, synchronous) returns line and column to 1 and empties the queue.
// ----------------------------------------------------------------------------
// streaming_source_lexer: top level
// Scanner front feeding a token queue back end.
// ----------------------------------------------------------------------------
module streaming_source_lexer #(
  parameter int LINE_WIDTH   = ssl_pkg::LINE_W_DEF,
  parameter int COLUMN_WIDTH = ssl_pkg::COL_W_DEF,
  parameter int LENGTH_WIDTH = ssl_pkg::LEN_W_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_source_byte,
  input  logic                    in_end_of_input,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [5:0]              out_token_kind,
  output logic [LINE_WIDTH-1:0]   out_token_line,
  output logic [COLUMN_WIDTH-1:0] out_token_column,
  output logic [LENGTH_WIDTH-1:0] out_token_length,
  output logic                    out_bool_true,
  output logic                    out_last_of_run
);

  logic          q_room2;
  logic [1:0]    tok_cnt;
  ssl_pkg::tok_t tok_a, tok_b;

  ssl_front #(.LINE_WIDTH(LINE_WIDTH), .COLUMN_WIDTH(COLUMN_WIDTH),
              .LENGTH_WIDTH(LENGTH_WIDTH)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_source_byte, .in_end_of_input,
    .q_room2, .tok_cnt, .tok_a, .tok_b
  );

  ssl_back #(.LINE_WIDTH(LINE_WIDTH), .COLUMN_WIDTH(COLUMN_WIDTH),
             .LENGTH_WIDTH(LENGTH_WIDTH)) u_back (
    .clk, .rst_n, .tok_cnt, .tok_a, .tok_b, .q_room2, .out_valid, .out_ready,
    .out_token_kind, .out_token_line, .out_token_column, .out_token_length,
    .out_bool_true, .out_last_of_run
  );

endmodule

// ===== sv/ssl_front.sv =====
// ----------------------------------------------------------------------------
// ssl_front: scanner
// Takes one byte per cycle while the queue has room for two, tracks the scan
// state and issues up to two token requests per byte into the queue.
// ----------------------------------------------------------------------------
module ssl_front #(
  parameter int LINE_WIDTH   = ssl_pkg::LINE_W_DEF,
  parameter int COLUMN_WIDTH = ssl_pkg::COL_W_DEF,
  parameter int LENGTH_WIDTH = ssl_pkg::LEN_W_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_source_byte,
  input  logic           in_end_of_input,
  input  logic           q_room2,
  output logic [1:0]     tok_cnt,
  output ssl_pkg::tok_t  tok_a,
  output ssl_pkg::tok_t  tok_b
);

  ssl_pkg::mode_t mode_r, mode_nxt;
  ssl_pkg::op_t   op_r, op_nxt;
  logic                    quote_r, quote_nxt;
  logic                    point_r, point_nxt;
  logic [LINE_WIDTH-1:0]   line_r, line_nxt;
  logic [COLUMN_WIDTH-1:0] col_r, col_nxt;
  logic [COLUMN_WIDTH-1:0] scol_r, scol_nxt;
  logic [LENGTH_WIDTH-1:0] len_r, len_nxt;
  logic [ssl_pkg::NWORDS-1:0] wm_r, wm_nxt;

  logic [7:0] c;
  logic       fire, eoi;
  logic       sp, dig, alp, fresh;

  assign in_ready = q_room2;
  assign fire     = in_valid & in_ready;
  assign c        = in_source_byte;
  assign eoi      = in_end_of_input;
  assign sp  = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  assign dig = (c >= "0") && (c <= "9");
  assign alp = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");

  function automatic logic [ssl_pkg::NWORDS-1:0] match(
      logic [ssl_pkg::NWORDS-1:0] m, logic [LENGTH_WIDTH-1:0] l, logic [7:0] ch);
    logic [ssl_pkg::NWORDS-1:0] r;
    r = m;
    for (int i = 0; i < ssl_pkg::NWORDS; i++) begin
      if (32'(l) >= ssl_pkg::word_len(i) || ssl_pkg::word_char(i, int'(l)) != ch)
        r[i] = 1'b0;
    end
    return r;
  endfunction

  function automatic ssl_pkg::tok_t mk(logic [5:0] k, logic [LINE_WIDTH-1:0] ln,
      logic [COLUMN_WIDTH-1:0] cl, logic [LENGTH_WIDTH-1:0] lg, logic t);
    ssl_pkg::tok_t r;
    r.kind = k;
    r.line = 32'(ln);
    r.col  = 32'(cl);
    r.len  = 32'(lg);
    r.tru  = t;
    r.last = 1'b0;
    return r;
  endfunction

  // word lookup: first matching entry of the right length
  ssl_pkg::tok_t word_tok;
  always_comb begin
    logic found;
    found = 1'b0;
    word_tok = mk(ssl_pkg::K_IDENT, line_r, scol_r, len_r, 1'b0);
    for (int i = 0; i < ssl_pkg::NWORDS; i++) begin
      if (!found && wm_r[i] && 32'(len_r) == ssl_pkg::word_len(i)) begin
        found = 1'b1;
        if (i < ssl_pkg::WORD_NIX) word_tok.kind = ssl_pkg::K_KW0 + 6'(i);
        else if (i == ssl_pkg::WORD_NIX) word_tok.kind = ssl_pkg::K_UNKNOWN;
        else begin
          word_tok.kind = ssl_pkg::K_BOOL;
          word_tok.tru  = (i == ssl_pkg::WORD_JA);
        end
      end
    end
  end

  // scan step
  always_comb begin
    ssl_pkg::tok_t t [2];
    logic [1:0] n;
    logic [LENGTH_WIDTH-1:0] len_inc;
    t[0] = '0;
    t[1] = '0;
    n = 2'd0;
    fresh = 1'b0;
    mode_nxt = mode_r; op_nxt = op_r; quote_nxt = quote_r; point_nxt = point_r;
    line_nxt = line_r; col_nxt = col_r; scol_nxt = scol_r; len_nxt = len_r;
    wm_nxt = wm_r;
    len_inc = (len_r != '1) ? len_r + 1'b1 : len_r;
    if (eoi) begin
      unique case (mode_r)
        ssl_pkg::M_IDENT: begin t[0] = word_tok; n = 2'd1; end
        ssl_pkg::M_NUMBER: begin
          t[0] = mk(point_r ? ssl_pkg::K_FLOAT : ssl_pkg::K_INT, line_r, scol_r, len_r, 1'b0);
          n = 2'd1;
        end
        ssl_pkg::M_STRING: begin
          t[0] = mk(ssl_pkg::K_UNKNOWN, line_r, scol_r, len_r, 1'b0); n = 2'd1;
        end
        ssl_pkg::M_OPER: begin
          t[0] = mk(ssl_pkg::op_single(op_r), line_r, scol_r, LENGTH_WIDTH'(1), 1'b0);
          n = 2'd1;
        end
        default: ;
      endcase
      t[n[0]] = mk(ssl_pkg::K_END, line_r, col_r, '0, 1'b0);
      n = n + 2'd1;
      mode_nxt = ssl_pkg::M_IDLE; op_nxt = ssl_pkg::OP_NONE; quote_nxt = 1'b0;
      point_nxt = 1'b0; line_nxt = LINE_WIDTH'(1); col_nxt = COLUMN_WIDTH'(1);
      scol_nxt = COLUMN_WIDTH'(1); len_nxt = '0; wm_nxt = '1;
    end else begin
      unique case (mode_r)
        ssl_pkg::M_IDENT: begin
          if (alp || dig || c == "_") begin
            wm_nxt = match(wm_r, len_r, c);
            len_nxt = len_inc;
          end else begin
            t[0] = word_tok; n = 2'd1; mode_nxt = ssl_pkg::M_IDLE; fresh = 1'b1;
          end
        end
        ssl_pkg::M_NUMBER: begin
          if (dig || (c == "." && !point_r)) begin
            if (c == ".") point_nxt = 1'b1;
            len_nxt = len_inc;
          end else begin
            t[0] = mk(point_r ? ssl_pkg::K_FLOAT : ssl_pkg::K_INT, line_r, scol_r, len_r,
                      1'b0);
            n = 2'd1; mode_nxt = ssl_pkg::M_IDLE; fresh = 1'b1;
          end
        end
        ssl_pkg::M_STRING: begin
          if (c == (quote_r ? 8'h27 : 8'h22)) begin
            t[0] = mk(ssl_pkg::K_STRING, line_r, scol_r, len_r, 1'b0);
            n = 2'd1; mode_nxt = ssl_pkg::M_IDLE;
          end else len_nxt = len_inc;
        end
        ssl_pkg::M_OPER: begin
          if (c == "=" && (op_r == ssl_pkg::OP_EQ || op_r == ssl_pkg::OP_BANG ||
                           op_r == ssl_pkg::OP_LT || op_r == ssl_pkg::OP_GT)) begin
            t[0] = mk(ssl_pkg::K_EQEQ + 6'(op_r) - 6'd1, line_r, scol_r,
                      LENGTH_WIDTH'(2), 1'b0);
            n = 2'd1; op_nxt = ssl_pkg::OP_NONE; mode_nxt = ssl_pkg::M_IDLE;
          end else if (op_r == ssl_pkg::OP_SLASH && (c == "/" || c == "*")) begin
            op_nxt = ssl_pkg::OP_NONE;
            mode_nxt = (c == "/") ? ssl_pkg::M_LINECOM : ssl_pkg::M_BLOCK;
          end else begin
            t[0] = mk(ssl_pkg::op_single(op_r), line_r, scol_r, LENGTH_WIDTH'(1), 1'b0);
            n = 2'd1; op_nxt = ssl_pkg::OP_NONE; mode_nxt = ssl_pkg::M_IDLE;
            fresh = 1'b1;
          end
        end
        ssl_pkg::M_LINECOM: if (c == 8'h0A) mode_nxt = ssl_pkg::M_IDLE;
        ssl_pkg::M_BLOCK:   if (c == "*") mode_nxt = ssl_pkg::M_BLOCKSTAR;
        ssl_pkg::M_BLOCKSTAR: begin
          if (c == "/") mode_nxt = ssl_pkg::M_IDLE;
          else if (c != "*") mode_nxt = ssl_pkg::M_BLOCK;
        end
        default: begin mode_nxt = ssl_pkg::M_IDLE; fresh = 1'b1; end
      endcase
      // new lexeme start
      if (fresh) begin
        scol_nxt = col_r;
        if (sp) begin
        end else if (dig) begin
          mode_nxt = ssl_pkg::M_NUMBER; point_nxt = 1'b0; len_nxt = LENGTH_WIDTH'(1);
        end else if (c == 8'h22 || c == 8'h27) begin
          mode_nxt = ssl_pkg::M_STRING; quote_nxt = (c == 8'h27); len_nxt = '0;
        end else if (alp || c == "_") begin
          mode_nxt = ssl_pkg::M_IDENT;
          wm_nxt = match('1, '0, c);
          len_nxt = LENGTH_WIDTH'(1);
        end else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "/") begin
          mode_nxt = ssl_pkg::M_OPER;
          op_nxt = (c == "=") ? ssl_pkg::OP_EQ : (c == "!") ? ssl_pkg::OP_BANG :
                   (c == "<") ? ssl_pkg::OP_LT : (c == ">") ? ssl_pkg::OP_GT :
                   ssl_pkg::OP_SLASH;
        end else begin
          t[n[0]] = mk(ssl_pkg::single_kind(c), line_r, col_r, LENGTH_WIDTH'(1), 1'b0);
          n = n + 2'd1;
        end
      end
      // position counters
      if (c == 8'h0A) begin
        line_nxt = (line_r != '1) ? line_r + 1'b1 : line_r;
        col_nxt  = COLUMN_WIDTH'(1);
      end else begin
        col_nxt = (col_r != '1) ? col_r + 1'b1 : col_r;
      end
    end
    if (n == 2'd1) t[0].last = 1'b1;
    if (n == 2'd2) t[1].last = 1'b1;
    tok_a   = t[0];
    tok_b   = t[1];
    tok_cnt = fire ? n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ssl_pkg::M_IDLE; op_r <= ssl_pkg::OP_NONE; quote_r <= 1'b0;
      point_r <= 1'b0; line_r <= LINE_WIDTH'(1); col_r <= COLUMN_WIDTH'(1);
      scol_r <= COLUMN_WIDTH'(1); len_r <= '0; wm_r <= '1;
    end else if (fire) begin
      mode_r <= mode_nxt; op_r <= op_nxt; quote_r <= quote_nxt;
      point_r <= point_nxt; line_r <= line_nxt; col_r <= col_nxt;
      scol_r <= scol_nxt; len_r <= len_nxt; wm_r <= wm_nxt;
    end
  end

endmodule

// ===== sv/ssl_back.sv =====
// ----------------------------------------------------------------------------
// ssl_back: token queue and output stage
// Four-entry queue taking up to two requests a cycle; head drives the ports.
// ----------------------------------------------------------------------------
module ssl_back #(
  parameter int LINE_WIDTH   = ssl_pkg::LINE_W_DEF,
  parameter int COLUMN_WIDTH = ssl_pkg::COL_W_DEF,
  parameter int LENGTH_WIDTH = ssl_pkg::LEN_W_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [1:0]              tok_cnt,
  input  ssl_pkg::tok_t           tok_a,
  input  ssl_pkg::tok_t           tok_b,
  output logic                    q_room2,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [5:0]              out_token_kind,
  output logic [LINE_WIDTH-1:0]   out_token_line,
  output logic [COLUMN_WIDTH-1:0] out_token_column,
  output logic [LENGTH_WIDTH-1:0] out_token_length,
  output logic                    out_bool_true,
  output logic                    out_last_of_run
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  ssl_pkg::tok_t q_r [DEPTH];
  logic [AW-1:0] rd_r, wr_r;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          pop;
  ssl_pkg::tok_t h;

  assign pop       = out_valid & out_ready;
  assign out_valid = (cnt_r != '0);
  assign q_room2   = (cnt_r <= (AW+1)'(DEPTH - 2));
  assign cnt_nxt   = cnt_r + (AW+1)'(tok_cnt) - (AW+1)'(pop);

  // queue storage
  always_ff @(posedge clk) begin
    if (tok_cnt != 2'd0) q_r[wr_r] <= tok_a;
    if (tok_cnt == 2'd2) q_r[wr_r + 1'b1] <= tok_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0; wr_r <= '0; cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + AW'(tok_cnt);
      rd_r  <= rd_r + AW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  assign h = q_r[rd_r];
  assign out_token_kind   = h.kind;
  assign out_token_line   = h.line[LINE_WIDTH-1:0];
  assign out_token_column = h.col[COLUMN_WIDTH-1:0];
  assign out_token_length = h.len[LENGTH_WIDTH-1:0];
  assign out_bool_true    = h.tru;
  assign out_last_of_run  = h.last;

endmodule

// ===== sv/ssl_checker.sv =====
// ----------------------------------------------------------------------------
// ssl_checker: port-level checks
// Watches the top level's ports over time.
// ----------------------------------------------------------------------------
module ssl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_token_kind,
  input logic       out_bool_true,
  input logic       out_last_of_run
);

  // stalled token stays valid and keeps its kind
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind))
    else $error("stalled token changed");

  // boolean flag only on boolean tokens
  a_bool: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bool_true |-> out_token_kind == ssl_pkg::K_BOOL)
    else $error("bool flag on non-bool token");

  // end token always closes a run
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == ssl_pkg::K_END |-> out_last_of_run)
    else $error("end token not last");

  // no output right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind streaming_source_lexer ssl_checker u_ssl_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_token_kind, .out_bool_true,
  .out_last_of_run
);

// ===== tb/sv/lexer_token_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lexer_token_checker: token predictor and scoreboard for the source lexer
// Watches both channels, works out the tokens that each accepted byte
// gives, and compares every accepted token field by field, oldest first.
// ----------------------------------------------------------------------------
module lexer_token_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_source_byte,
  input  logic        in_end_of_input,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [5:0]  out_token_kind,
  input  logic [15:0] out_token_line,
  input  logic [11:0] out_token_column,
  input  logic [11:0] out_token_length,
  input  logic        out_bool_true,
  input  logic        out_last_of_run,
  output int          errors,
  output int          outstanding
);

  localparam logic [5:0] K_LPAREN  = 6'd32;
  localparam logic [5:0] K_PERCENT = 6'd45;
  localparam logic [5:0] K_COLON   = 6'd50;
  localparam string      SINGLE_OPS = "(){}[];,.+-*";

  typedef struct {
    logic [5:0]  kind;
    logic [15:0] line;
    logic [11:0] col;
    logic [11:0] len;
    logic        tru;
    logic        last;
  } token_t;

  string words [24] = '{"GANZ", "KOMMA", "WORT", "JAIN", "KISTE", "WENN", "SONST",
    "SOLANGE", "UND", "ODER", "NICHT", "FUER", "DRUCKE", "LESE", "ZU_GANZ",
    string'({"ZU_", "KOMMA"}), "ZU_WORT", "ZURUECK", "GIBFREI", "HOLE", "VON", "NIX",
    "JA", "NEIN"};

  token_t         tok_expected [$];
  ssl_pkg::mode_t mode;
  logic           quote_single;
  logic           has_point;
  ssl_pkg::op_t   held_op;
  logic [15:0]    line_no;
  logic [11:0]    col_no;
  logic [11:0]    tok_col;
  logic [11:0]    tok_len;
  logic [23:0]    word_hits;

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic void lexer_clear();
    mode = ssl_pkg::M_IDLE; quote_single = 0; has_point = 0; held_op = ssl_pkg::OP_NONE;
    line_no = 1; col_no = 1; tok_col = 1; tok_len = 0; word_hits = '1;
  endfunction

  function automatic void add_token(logic [5:0] k, logic [11:0] c, logic [11:0] l,
                                    logic t);
    token_t tk;
    tk = '{k, line_no, c, l, t, 1'b0};
    tok_expected = {tok_expected, tk};
  endfunction

  function automatic void match_letter(logic [7:0] c);
    for (int i = 0; i < 24; i++)
      if (tok_len >= words[i].len() || words[i][tok_len] != c) word_hits[i] = 1'b0;
  endfunction

  function automatic void add_word();
    logic [5:0] k;
    logic       t;
    bit         found;
    k = ssl_pkg::K_IDENT; t = 0; found = 0;
    for (int i = 0; i < 24; i++) begin
      if (!found && word_hits[i] && words[i].len() == tok_len) begin
        found = 1;
        if (i < ssl_pkg::WORD_NIX) k = ssl_pkg::K_KW0 + 6'(i);
        else if (i == ssl_pkg::WORD_NIX) k = ssl_pkg::K_UNKNOWN;
        else begin
          k = ssl_pkg::K_BOOL; t = (i == ssl_pkg::WORD_JA);
        end
      end
    end
    add_token(k, tok_col, tok_len, t);
  endfunction

  function automatic void add_lone_op();
    logic [5:0] k;
    case (held_op)
      ssl_pkg::OP_EQ:    k = ssl_pkg::K_ASSIGN;
      ssl_pkg::OP_BANG:  k = ssl_pkg::K_BANG;
      ssl_pkg::OP_LT:    k = ssl_pkg::K_LT;
      ssl_pkg::OP_GT:    k = ssl_pkg::K_GT;
      ssl_pkg::OP_SLASH: k = ssl_pkg::K_SLASH;
      default:           k = ssl_pkg::K_UNKNOWN;
    endcase
    add_token(k, tok_col, 12'd1, 1'b0);
    held_op = ssl_pkg::OP_NONE;
  endfunction

  function automatic void begin_lexeme(logic [7:0] c);
    logic [5:0] k;
    tok_col = col_no;
    if (is_blank(c)) begin
    end else if (is_num(c)) begin
      mode = ssl_pkg::M_NUMBER; has_point = 0; tok_len = 1;
    end else if (c == "\"" || c == "'") begin
      mode = ssl_pkg::M_STRING; quote_single = (c == "'"); tok_len = 0;
    end else if (is_letter(c) || c == "_") begin
      mode = ssl_pkg::M_IDENT; word_hits = '1; tok_len = 0;
      match_letter(c);
      tok_len = 1;
    end else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "/") begin
      mode = ssl_pkg::M_OPER;
      held_op = c == "=" ? ssl_pkg::OP_EQ : c == "!" ? ssl_pkg::OP_BANG :
                c == "<" ? ssl_pkg::OP_LT : c == ">" ? ssl_pkg::OP_GT : ssl_pkg::OP_SLASH;
    end else begin
      k = ssl_pkg::K_UNKNOWN;
      for (int i = 0; i < SINGLE_OPS.len(); i++)
        if (SINGLE_OPS[i] == c) k = K_LPAREN + 6'(i);
      if (c == "%") k = K_PERCENT;
      if (c == ":") k = K_COLON;
      add_token(k, tok_col, 12'd1, 1'b0);
    end
  endfunction

  // One accepted byte: queue the tokens it ends
  function automatic void lex_byte(logic [7:0] c, logic eoi);
    int  n_prior;
    bit  fresh;
    n_prior = tok_expected.size();
    fresh = 0;
    if (eoi) begin
      case (mode)
        ssl_pkg::M_IDENT:  add_word();
        ssl_pkg::M_NUMBER:
          add_token(has_point ? ssl_pkg::K_FLOAT : ssl_pkg::K_INT, tok_col, tok_len, 1'b0);
        ssl_pkg::M_STRING: add_token(ssl_pkg::K_UNKNOWN, tok_col, tok_len, 1'b0);
        ssl_pkg::M_OPER:   add_lone_op();
        default: ;
      endcase
      add_token(ssl_pkg::K_END, col_no, 12'd0, 1'b0);
      tok_expected[tok_expected.size()-1].last = 1'b1;
      lexer_clear();
      return;
    end
    case (mode)
      ssl_pkg::M_IDENT:
        if (is_letter(c) || is_num(c) || c == "_") begin
          match_letter(c);
          if (tok_len != '1) tok_len++;
        end else begin
          add_word(); mode = ssl_pkg::M_IDLE; fresh = 1;
        end
      ssl_pkg::M_NUMBER:
        if (is_num(c) || (c == "." && !has_point)) begin
          if (c == ".") has_point = 1;
          if (tok_len != '1) tok_len++;
        end else begin
          add_token(has_point ? ssl_pkg::K_FLOAT : ssl_pkg::K_INT, tok_col, tok_len, 1'b0);
          mode = ssl_pkg::M_IDLE; fresh = 1;
        end
      ssl_pkg::M_STRING:
        if (c == (quote_single ? "'" : "\"")) begin
          add_token(ssl_pkg::K_STRING, tok_col, tok_len, 1'b0);
          mode = ssl_pkg::M_IDLE;
        end else if (tok_len != '1) tok_len++;
      ssl_pkg::M_OPER:
        if (c == "=" && held_op inside {ssl_pkg::OP_EQ, ssl_pkg::OP_BANG, ssl_pkg::OP_LT,
                                        ssl_pkg::OP_GT}) begin
          add_token(ssl_pkg::K_EQEQ + 6'(held_op - ssl_pkg::OP_EQ), tok_col, 12'd2, 1'b0);
          held_op = ssl_pkg::OP_NONE; mode = ssl_pkg::M_IDLE;
        end else if (held_op == ssl_pkg::OP_SLASH && (c == "/" || c == "*")) begin
          held_op = ssl_pkg::OP_NONE;
          mode = (c == "/") ? ssl_pkg::M_LINECOM : ssl_pkg::M_BLOCK;
        end else begin
          add_lone_op(); mode = ssl_pkg::M_IDLE; fresh = 1;
        end
      ssl_pkg::M_LINECOM:   if (c == "\n") mode = ssl_pkg::M_IDLE;
      ssl_pkg::M_BLOCK:     if (c == "*") mode = ssl_pkg::M_BLOCKSTAR;
      ssl_pkg::M_BLOCKSTAR:
        if (c == "/") mode = ssl_pkg::M_IDLE;
        else if (c != "*") mode = ssl_pkg::M_BLOCK;
      default: begin
        mode = ssl_pkg::M_IDLE; fresh = 1;
      end
    endcase
    if (fresh) begin_lexeme(c);
    // column and line counting, saturating
    if (c == "\n") begin
      if (line_no != '1) line_no++;
      col_no = 1;
    end else if (col_no != '1) col_no++;
    if (tok_expected.size() > n_prior) tok_expected[tok_expected.size()-1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    errors = 0;
    outstanding = 0;
  end

  // Compare accepted tokens first, then predict from the accepted byte
  always @(posedge clk) begin
    token_t w;
    if (!rst_n) begin
      lexer_clear();
      tok_expected.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (tok_expected.size() == 0) report_mismatch("unexpected token kind",
                                                      out_token_kind, -1);
        else begin
          w = tok_expected.pop_front();
          if (out_token_kind !== w.kind) report_mismatch("kind", out_token_kind, w.kind);
          if (out_token_line !== w.line) report_mismatch("line", out_token_line, w.line);
          if (out_token_column !== w.col)
            report_mismatch("column", out_token_column, w.col);
          if (out_token_length !== w.len)
            report_mismatch("length", out_token_length, w.len);
          if (out_bool_true !== w.tru) report_mismatch("bool", out_bool_true, w.tru);
          if (out_last_of_run !== w.last)
            report_mismatch("last", out_last_of_run, w.last);
        end
      end
      if (in_valid && in_ready) lex_byte(in_source_byte, in_end_of_input);
    end
    outstanding = tok_expected.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the streaming source lexer
// Feeds directed source text and random lexeme streams
// with random idling on both sides; the checker does the prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STALL_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_source_byte;
  logic        in_end_of_input;
  logic        out_valid;
  logic        out_ready;
  logic [5:0]  out_token_kind;
  logic [15:0] out_token_line;
  logic [11:0] out_token_column;
  logic [11:0] out_token_length;
  logic        out_bool_true;
  logic        out_last_of_run;
  int          errors;
  int          outstanding;
  int          quiet_cycles;
  int          bytes_sent;
  bit          calm;

  string words [24] = '{"GANZ", "KOMMA", "WORT", "JAIN", "KISTE", "WENN", "SONST",
    "SOLANGE", "UND", "ODER", "NICHT", "FUER", "DRUCKE", "LESE", "ZU_GANZ",
    string'({"ZU_", "KOMMA"}), "ZU_WORT", "ZURUECK", "GIBFREI", "HOLE", "VON", "NIX",
    "JA", "NEIN"};
  string ops [23] = '{"==", "!=", "<=", ">=", "(", ")", "{", "}", "[", "]", ";", ",",
    ".", "+", "-", "*", "/", "%", "=", "<", ">", "!", ":"};

  streaming_source_lexer u_top (.*);

  lexer_token_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Result side stalls at random unless in a calm stretch
  always @(negedge clk) out_ready <= calm || ($urandom_range(99) >= 37);

  // Watchdog: cycles with no accepted request on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic eoi);
    if (!calm && $urandom_range(99) < 37) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end else @(negedge clk);
    in_valid        <= 1'b1;
    in_source_byte  <= b;
    in_end_of_input <= eoi;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic finish_source();
    send_byte(8'($urandom), 1'b1);
  endtask

  // One random lexeme, mostly well formed
  task automatic random_lexeme();
    string s;
    int    n;
    case ($urandom_range(11))
      0, 1: s = words[$urandom_range(23)];
      2: begin
        s = "";
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          s = {s, string'(8'("a" + $urandom_range(25)))};
        if ($urandom_range(1)) s = {s, "_9"};
      end
      3: begin
        s.itoa($urandom_range(99999));
        if ($urandom_range(1)) s = {s, ".", $sformatf("%0d", $urandom_range(999))};
        if ($urandom_range(3) == 0) s = {s, ".5"};
      end
      4: begin
        s = $urandom_range(1) ? "'" : "\"";
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(32, 126)))};
        if ($urandom_range(5) != 0) s = {s, s.substr(0, 0)};
      end
      5, 6: s = ops[$urandom_range(22)];
      7: s = $urandom_range(1) ? "// note \n" : "/* x * / ** */";
      8: s = $urandom_range(1) ? " " : "\n";
      9: s = "\t";
      default: begin
        // noise byte, any value
        send_byte(8'($urandom), 1'b0);
        s = " ";
      end
    endcase
    send_text(s);
    if ($urandom_range(2) == 0) send_byte(" ", 1'b0);
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_source_byte = 0; in_end_of_input = 0;
    out_ready = 0; calm = 0; quiet_cycles = 0; bytes_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1;

    // Directed: every word, every operator, comments, numbers, strings
    for (int i = 0; i < 24; i++) send_text({words[i], " "});
    for (int i = 0; i < 23; i++) send_text({ops[i], " "});
    send_text("x1_ 12 3.4 5.6.7 'ab' \"c'd\" // rest\n/*/ y */ /**/ q");
    send_byte(8'hFF, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h00, 1'b0);
    send_text("@'"); send_byte(8'hFF, 1'b0);
    finish_source();                     // open string at end
    send_text("a <"); finish_source();   // lone comparison at end
    send_text("/"); finish_source();     // lone slash at end
    send_text("/* open"); finish_source();
    send_text("JA"); finish_source();
    send_text("7.5"); finish_source();

    // Random streams, a calm stretch, and one drain pause
    for (int k = 0; k < 170; k++) begin
      calm = (k >= 60 && k < 100);
      random_lexeme();
      if ($urandom_range(40) == 0) finish_source();
      if (k == 120) begin
        @(negedge clk) in_valid <= 1'b0;
        wait (outstanding == 0);
      end
    end
    calm = 0;
    finish_source();

    // Drain
    @(negedge clk) in_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
